/* rtl/polar_grid_min_height_binning_assert.svh */
// Assertion macros for the binning block.
`ifndef POLAR_GRID_MIN_HEIGHT_BINNING_ASSERT_SVH
`define POLAR_GRID_MIN_HEIGHT_BINNING_ASSERT_SVH

`define PG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

`define PG_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/pgb_pkg.sv */
`default_nettype none
package pgb_pkg;
  localparam int unsigned CordicSteps = 28;
  localparam logic signed [15:0] EmptyHeight = 16'sh7fff;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SQRT,
    ST_CORDIC,
    ST_CHMUL,
    ST_BINMUL,
    ST_DIV,
    ST_RDREQ,
    ST_RDWAIT,
    ST_UPDATE,
    ST_OUT
  } state_e;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0:  r = 32'd536870912;
        5'd1:  r = 32'd316933406;
        5'd2:  r = 32'd167458907;
        5'd3:  r = 32'd85004756;
        5'd4:  r = 32'd42667331;
        5'd5:  r = 32'd21354465;
        5'd6:  r = 32'd10679838;
        5'd7:  r = 32'd5340245;
        5'd8:  r = 32'd2670163;
        5'd9:  r = 32'd1335087;
        5'd10: r = 32'd667544;
        5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;
        5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;
        5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;
        5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;
        5'd19: r = 32'd1304;
        5'd20: r = 32'd652;
        5'd21: r = 32'd326;
        5'd22: r = 32'd163;
        5'd23: r = 32'd81;
        5'd24: r = 32'd41;
        5'd25: r = 32'd20;
        5'd26: r = 32'd10;
        5'd27: r = 32'd5;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

/* rtl/pgb_sqrt.sv */
`default_nettype none
// Digit-serial integer square root, two radicand bits per cycle.
module pgb_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] rad_i,
  output logic             done_o,
  output logic [15:0]      root_o
);
  logic [31:0] rad_q, rad_d;
  logic [17:0] rem_q, rem_d;
  logic [15:0] root_q, root_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [17:0] trial;
  logic [17:0] shifted;

  always_comb begin
    shifted = {rem_q[15:0], rad_q[31:30]};
    trial   = {root_q, 2'b01};
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[29:0], 2'b00};
      if (shifted >= trial) begin
        rem_d  = shifted - trial;
        root_d = {root_q[14:0], 1'b1};
      end else begin
        rem_d  = shifted;
        root_d = {root_q[14:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd15) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = busy_q && (cnt_q == 5'd15);
  assign root_o = root_d;
endmodule
`default_nettype wire

/* rtl/pgb_cordic.sv */
`default_nettype none
// Iterative CORDIC vectoring, one micro-rotation per cycle, angle in turns.
module pgb_cordic (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [15:0] x_i,
  input  wire logic signed [15:0] y_i,
  output logic                    done_o,
  output logic signed [33:0]      ang_o
);
  import pgb_pkg::*;

  logic signed [35:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [33:0] acc_q, acc_d;
  logic [4:0]         i_q, i_d;
  logic               busy_q, busy_d;
  logic               fix_q, fix_d;
  logic signed [35:0] sx, sy, ix, iy;
  logic signed [33:0] tab;

  always_comb begin
    ix = {{4{x_i[15]}}, x_i, 16'd0};
    iy = {{4{y_i[15]}}, y_i, 16'd0};
    sx = cx_q >>> i_q;
    sy = cy_q >>> i_q;
    tab = $signed({2'b00, atan_turn(i_q)});
    cx_d = cx_q;
    cy_d = cy_q;
    acc_d = acc_q;
    i_d = i_q;
    busy_d = busy_q;
    fix_d = fix_q;
    if (start_i) begin
      busy_d = 1'b1;
      i_d = '0;
      // axis points carry an exact angle
      fix_d = (y_i == 16'sd0) || (x_i == 16'sd0);
      cx_d = ix; cy_d = iy; acc_d = '0;
      if (y_i == 16'sd0) begin
        acc_d = x_i[15] ? 34'sd2147483648 : 34'sd0;
      end else if (x_i == 16'sd0) begin
        acc_d = y_i[15] ? -34'sd1073741824 : 34'sd1073741824;
      end else if (x_i[15]) begin
        if (!y_i[15] && y_i != 16'sd0) begin
          cx_d = iy; cy_d = -ix; acc_d = 34'sd1073741824;
        end else begin
          cx_d = -iy; cy_d = ix; acc_d = -34'sd1073741824;
        end
      end
    end else if (busy_q) begin
      if (cy_q > 36'sd0) begin
        cx_d = cx_q + sy; cy_d = cy_q - sx; acc_d = acc_q + tab;
      end else begin
        cx_d = cx_q - sy; cy_d = cy_q + sx; acc_d = acc_q - tab;
      end
      if (fix_q) acc_d = acc_q;
      i_d = i_q + 5'd1;
      if (i_q == 5'(CordicSteps - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      i_q <= '0;
    end else begin
      busy_q <= busy_d;
      i_q <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q <= cx_d;
    cy_q <= cy_d;
    acc_q <= acc_d;
    fix_q <= fix_d;
  end

  assign done_o = busy_q && (i_q == 5'(CordicSteps - 1));
  assign ang_o = acc_d;
endmodule
`default_nettype wire

/* rtl/pgb_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module pgb_div #(
  parameter int unsigned NumW = 26,
  parameter int unsigned DenW = 15
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 done_o,
  output logic [NumW-1:0]      quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q, num_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [DenW:0]   sh;

  always_comb begin
    sh = {rem_q[DenW-1:0], num_q[NumW-1]};
    num_d = num_q;
    den_d = den_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      num_d = num_i;
      den_d = den_i;
      rem_d = '0;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (sh >= {1'b0, den_q}) begin
        rem_d = sh - {1'b0, den_q};
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = sh;
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(NumW - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = busy_q && (cnt_q == CntW'(NumW - 1));
  assign quo_o = num_d;
endmodule
`default_nettype wire

/* rtl/polar_grid_min_height_binning.sv */
`default_nettype none
// Polar-grid minimum-height binning.
// Input channel (in_valid_i/in_ready_o): op 0 inserts a point (x, y, z),
// op 1 reads one cell (read_channel, read_bin) and clears it to empty (32767).
// Output channel (out_valid_o/out_ready_i): one result beat per input beat.
// Config: cfg_we_i/cfg_idx_i/cfg_data_i, index 0 min_radius, 1 max_radius.
// One item at a time. An insert runs a square root (two bits a cycle),
// a CORDIC, a channel multiply, a bin multiply and a bit-serial divide
// (one numerator bit per cycle), then a read-modify-write of the cell
// memory before its result shows. A point dropped on radius or angle goes
// from the CORDIC step straight to the output; a read does only the
// read-modify-write, and a read outside the grid skips that as well.
// The CORDIC and divide loops are the longest steps of an insert.
// After reset a clearing pass writes every cell empty, one cell a cycle
// (CHANNELS*BINS cells, 9600 by default) before the first beat is taken.
// A finished result sits in the output register until taken; the next input
// beat is taken once the result register is free.
module polar_grid_min_height_binning #(
  parameter int unsigned CHANNELS = 80,
  parameter int unsigned BINS = 120
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               op_i,
  input  wire logic signed [15:0] x_pos_i,
  input  wire logic signed [15:0] y_pos_i,
  input  wire logic signed [15:0] z_pos_i,
  input  wire logic [6:0]         read_channel_i,
  input  wire logic [6:0]         read_bin_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    accepted_o,
  output logic [6:0]              channel_index_o,
  output logic [6:0]              bin_index_o,
  output logic signed [15:0]      min_height_o,
  input  wire logic               cfg_we_i,
  input  wire logic [0:0]         cfg_idx_i,
  input  wire logic [14:0]        cfg_data_i
);
  import pgb_pkg::*;

  localparam int unsigned Depth = CHANNELS * BINS;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned ChW = $clog2(CHANNELS);
  localparam int unsigned BnW = $clog2(BINS);
  localparam int unsigned ChMW = $clog2(CHANNELS + 1);
  localparam int unsigned BinMW = $clog2(BINS + 1);
  localparam int unsigned NumW = 15 + BinMW;

  state_e state_q, state_d;
  logic [14:0] rmin_q, rmax_q;
  logic signed [15:0] x_q, y_q, z_q;
  logic op_q;
  logic [15:0] d_q;
  logic [33:0] t_q;
  logic [10:0] ch_q;
  logic [AddrW-1:0] addr_q, clr_q;
  logic [NumW-1:0] bn_q;
  logic drop_q;
  logic signed [15:0] mem [Depth];
  logic signed [15:0] rd_q;
  logic ov_q, acc_q;
  logic [6:0] och_q, obn_q;
  logic signed [15:0] omin_q;

  logic sq_start, sq_done, co_start, co_done, dv_start, dv_done;
  logic [15:0] sq_root;
  logic signed [33:0] co_ang;
  logic [NumW-1:0] dv_quo;
  logic [31:0] rad;
  logic in_fire;
  logic [14:0] span;
  logic signed [33:0] tcl;
  logic [ChMW+31:0] chprod;
  logic [NumW-1:0] binprod;
  logic [AddrW-1:0] idx;
  logic drop_rad;
  logic signed [15:0] newv;

  // root starts on the input beat, so square the port values
  assign rad = 32'(x_pos_i * x_pos_i) + 32'(y_pos_i * y_pos_i);
  assign span = rmax_q - rmin_q;
  assign in_fire = in_valid_i && in_ready_o;

  pgb_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .rad_i(rad), .done_o(sq_done), .root_o(sq_root)
  );
  pgb_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(co_start), .x_i(x_q), .y_i(y_q), .done_o(co_done),
    .ang_o(co_ang)
  );
  pgb_div #(.NumW(NumW), .DenW(15)) u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(binprod), .den_i(span), .done_o(dv_done),
    .quo_o(dv_quo)
  );

  always_comb begin
    drop_rad = (d_q <= {1'b0, rmin_q}) || (d_q >= {1'b0, rmax_q}) || (rmax_q <= rmin_q)
               || (y_q == 16'sd0 && x_q[15]);
    tcl = co_ang + 34'sh080000000;
    if (tcl < 0) tcl = '0;
    else if (tcl > 34'shFFFFFFFF) tcl = 34'shFFFFFFFF;
    chprod = (ChMW + 32)'(t_q[31:0]) * (ChMW + 32)'(CHANNELS);
    binprod = NumW'(d_q[14:0] - rmin_q) * NumW'(BINS);
    idx = AddrW'(ch_q * BINS) + AddrW'(bn_q);
    newv = (z_q < rd_q) ? z_q : rd_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == AddrW'(Depth - 1)) state_d = ST_IDLE;
      ST_IDLE: if (in_fire) state_d = (op_i == OP_READ) ? ST_RDREQ : ST_SQRT;
      ST_SQRT: if (sq_done) state_d = ST_CORDIC;
      ST_CORDIC: begin
        if (drop_q) state_d = ST_OUT;
        else if (co_done) state_d = ST_CHMUL;
      end
      ST_CHMUL: state_d = ST_BINMUL;
      ST_BINMUL: state_d = ST_DIV;
      ST_DIV: if (dv_done) state_d = ST_RDREQ;
      ST_RDREQ: state_d = drop_q ? ST_OUT : ST_RDWAIT;
      ST_RDWAIT: state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_OUT;
      ST_OUT: if (!ov_q) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE) && !ov_q;
    sq_start = (state_q == ST_IDLE) && in_fire && (op_i == OP_INSERT);
    co_start = (state_q == ST_SQRT) && sq_done;
    dv_start = (state_q == ST_BINMUL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      rmin_q <= 15'd870;
      rmax_q <= 15'd30720;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (cfg_we_i) begin
        if (cfg_idx_i == 1'b0) rmin_q <= cfg_data_i;
        else rmax_q <= cfg_data_i;
      end
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      else if (state_q == ST_UPDATE || (state_q == ST_OUT && !ov_q && state_d == ST_IDLE
               && acc_q == 1'b0 && !ov_q)) ov_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q <= op_i; x_q <= x_pos_i; y_q <= y_pos_i; z_q <= z_pos_i;
      drop_q <= (op_i == OP_READ) &&
                ((32'(read_channel_i) >= CHANNELS) || (32'(read_bin_i) >= BINS));
      ch_q <= 11'(read_channel_i);
      bn_q <= NumW'(read_bin_i);
      acc_q <= 1'b0;
    end
    if (state_q == ST_SQRT && sq_done) d_q <= sq_root;
    if (state_q == ST_CORDIC && !co_done) drop_q <= drop_rad;
    if (state_q == ST_CORDIC && co_done) t_q <= tcl;
    if (state_q == ST_CHMUL) ch_q <= 11'(chprod[ChMW+31:32]);
    if (state_q == ST_DIV && dv_done) bn_q <= dv_quo;
    if (state_q == ST_RDREQ) begin
      if (32'(ch_q) >= CHANNELS || 32'(bn_q) >= BINS) drop_q <= 1'b1;
      addr_q <= idx;
    end
    if (state_q == ST_CLEAR) mem[clr_q] <= EmptyHeight;
    else if (state_q == ST_UPDATE) mem[addr_q] <= (op_q == OP_READ) ? EmptyHeight : newv;
    if (state_q == ST_RDWAIT) rd_q <= mem[addr_q];
    if (state_q == ST_UPDATE) begin
      acc_q <= 1'b1;
      och_q <= ch_q[6:0];
      obn_q <= bn_q[6:0];
      omin_q <= (op_q == OP_READ) ? rd_q : newv;
    end else if (state_q == ST_OUT && !ov_q && !acc_q) begin
      och_q <= '0; obn_q <= '0; omin_q <= '0;
    end
  end

  assign out_valid_o = ov_q;
  assign accepted_o = acc_q;
  assign channel_index_o = och_q;
  assign bin_index_o = obn_q;
  assign min_height_o = omin_q;
endmodule
`default_nettype wire

/* rtl/pgb_checker.sv */
`default_nettype none
`include "polar_grid_min_height_binning_assert.svh"
module pgb_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic accepted_o,
  input wire logic [6:0] channel_index_o,
  input wire logic signed [15:0] min_height_o
);
  `PG_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(min_height_o))
  `PG_ASSERT_IMP(a_no_take_busy, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `PG_ASSERT_IMP(a_drop_zero, clk_i, rst_ni, out_valid_o && !accepted_o, channel_index_o == 7'd0 && min_height_o == 16'sd0)
  `PG_ASSERT_NXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
endmodule

bind polar_grid_min_height_binning pgb_checker u_pgb_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .accepted_o,
  .channel_index_o, .min_height_o
);
`default_nettype wire

/* bench/testbench.sv */
module testbench;
  import pgb_pkg::*;

  localparam int unsigned NumChannels = 80;
  localparam int unsigned NumBins = 120;
  localparam int unsigned NumCells = NumChannels * NumBins;
  localparam int unsigned StallLimit = 40000;
  localparam int unsigned SettleCycles = 200;
  localparam logic [0:0] RegMinRadius = 1'b0;
  localparam logic [0:0] RegMaxRadius = 1'b1;

  typedef struct packed {
    logic              accepted;
    logic [6:0]        channel_index;
    logic [6:0]        bin_index;
    logic signed [15:0] min_height;
  } cell_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic op_i = 1'b0;
  logic signed [15:0] x_pos_i = '0;
  logic signed [15:0] y_pos_i = '0;
  logic signed [15:0] z_pos_i = '0;
  logic [6:0] read_channel_i = '0;
  logic [6:0] read_bin_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic accepted_o;
  logic [6:0] channel_index_o;
  logic [6:0] bin_index_o;
  logic signed [15:0] min_height_o;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_idx_i = '0;
  logic [14:0] cfg_data_i = '0;

  polar_grid_min_height_binning dut (.*);

  always #4 clk_i = ~clk_i;

  logic [14:0] inner_radius;
  logic [14:0] outer_radius;
  logic signed [15:0] cell_floor [NumCells];
  cell_result_t pending_cells[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned hits_seen = 0;
  int unsigned idle_cycles = 0;
  bit idling_on = 1'b1;
  bit timed_out = 1'b0;

  localparam longint TurnAtan [28] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
  };

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint radial_root(longint v);
    longint root, bit_w;
    root = 0;
    bit_w = 64'd1 << 32;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= root + bit_w) begin
        v = v - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return root;
  endfunction

  function automatic longint bearing_turns(longint x, longint y);
    longint cx, cy, nx, ny, acc;
    acc = 0;
    if (y == 0) return (x < 0) ? (64'sd1 <<< 31) : 0;
    if (x == 0) return (y > 0) ? (64'sd1 <<< 30) : -(64'sd1 <<< 30);
    cx = x * 65536;
    cy = y * 65536;
    if (cx < 0) begin
      if (cy > 0) begin
        nx = cy; ny = -cx; acc = 64'sd1 <<< 30;
      end else begin
        nx = -cy; ny = cx; acc = -(64'sd1 <<< 30);
      end
      cx = nx; cy = ny;
    end
    for (int i = 0; i < 28; i++) begin
      if (cy > 0) begin
        nx = cx + floor_shr(cy, i);
        ny = cy - floor_shr(cx, i);
        acc += TurnAtan[i];
      end else begin
        nx = cx - floor_shr(cy, i);
        ny = cy + floor_shr(cx, i);
        acc -= TurnAtan[i];
      end
      cx = nx; cy = ny;
    end
    return acc;
  endfunction

  function automatic cell_result_t predict_cell(op_e op, logic signed [15:0] x,
      logic signed [15:0] y, logic signed [15:0] z, logic [6:0] rch, logic [6:0] rbn);
    cell_result_t r;
    longint xs, ys, d, t, ch, bn;
    int idx;
    r = '0;
    if (op == OP_READ) begin
      if (rch >= NumChannels || rbn >= NumBins) return r;
      idx = rch * NumBins + rbn;
      r = '{1'b1, rch, rbn, cell_floor[idx]};
      cell_floor[idx] = EmptyHeight;
      return r;
    end
    xs = x;
    ys = y;
    d = radial_root(xs * xs + ys * ys);
    if (d <= inner_radius || d >= outer_radius || outer_radius <= inner_radius) return r;
    if (ys == 0 && xs < 0) return r;
    t = bearing_turns(xs, ys) + (64'sd1 <<< 31);
    if (t < 0) t = 0;
    if (t > 64'sh0FFFFFFFF) t = 64'sh0FFFFFFFF;
    ch = (t * NumChannels) >> 32;
    bn = ((d - inner_radius) * NumBins) / (outer_radius - inner_radius);
    if (ch >= NumChannels || bn >= NumBins) return r;
    idx = ch * NumBins + bn;
    if (z < cell_floor[idx]) cell_floor[idx] = z;
    r = '{1'b1, ch[6:0], bn[6:0], cell_floor[idx]};
    return r;
  endfunction

  task automatic idle_burst();
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic send_item(op_e op, logic signed [15:0] x, logic signed [15:0] y,
      logic signed [15:0] z, logic [6:0] rch, logic [6:0] rbn);
    idle_burst();
    in_valid_i <= 1'b1;
    op_i <= op;
    x_pos_i <= x;
    y_pos_i <= y;
    z_pos_i <= z;
    read_channel_i <= rch;
    read_bin_i <= rbn;
    do @(posedge clk_i); while (!in_ready_o);
    pending_cells = {pending_cells, predict_cell(op, x, y, z, rch, rbn)};
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [14:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    if (idx == RegMinRadius) inner_radius = value;
    else outer_radius = value;
  endtask

  task automatic set_radii(logic [14:0] lo, logic [14:0] hi);
    drain();
    write_reg(RegMinRadius, lo);
    write_reg(RegMaxRadius, hi);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
      logic signed [15:0] z);
    send_item(OP_INSERT, x, y, z, 7'($urandom), 7'($urandom));
  endtask

  task automatic send_read(logic [6:0] rch, logic [6:0] rbn);
    send_item(OP_READ, 16'($urandom), 16'($urandom), 16'($urandom), rch, rbn);
  endtask

  task automatic test_directed();
    send_point(16'sd4000, 16'sd0, -16'sd32768);
    send_point(-16'sd4000, 16'sd0, 16'sd5);
    send_point(16'sd0, 16'sd4000, 16'sd100);
    send_point(16'sd0, -16'sd4000, 16'sd32766);
    send_point(-16'sd32768, -16'sd32768, 16'sd7);
    send_point(16'sd32767, 16'sd32767, 16'sd7);
    send_point(16'sd10, 16'sd10, 16'sd0);
    send_point(16'sd3000, 16'sd3000, 16'sd32767);
    send_point(16'sd3000, 16'sd3000, -16'sd20);
    send_point(16'sd3000, 16'sd3000, 16'sd50);
    send_point(-16'sd3000, 16'sd2000, -16'sd1);
    send_point(-16'sd3000, -16'sd2000, -16'sd1);
    send_read(7'd0, 7'd0);
    send_read(7'd79, 7'd119);
    send_read(7'd80, 7'd0);
    send_read(7'd0, 7'd120);
    send_read(7'd127, 7'd127);
  endtask

  task automatic test_radius_settings();
    set_radii(15'd0, 15'd32767);
    send_point(16'sd1, 16'sd0, 16'sd3);
    send_point(16'sd23170, 16'sd23170, 16'sd3);
    send_point(-16'sd32768, 16'sd1, 16'sd3);
    set_radii(15'd5000, 15'd5000);
    send_point(16'sd5000, 16'sd100, 16'sd3);
    set_radii(15'd32767, 15'd1);
    send_point(16'sd20000, 16'sd20000, 16'sd3);
    set_radii(15'd1000, 15'd1002);
    send_point(16'sd1001, 16'sd0, 16'sd3);
    send_point(16'sd0, -16'sd1001, 16'sd3);
  endtask

  task automatic random_burst(int unsigned count);
    int unsigned r, rad;
    for (int unsigned i = 0; i < count; i++) begin
      r = $urandom_range(0, 9);
      rad = $urandom_range(0, 1) ? 8000 : 32767;
      if (r < 6)
        send_point(16'($signed($urandom_range(0, 2 * rad)) - rad),
                   16'($signed($urandom_range(0, 2 * rad)) - rad),
                   16'($signed($urandom_range(0, 500)) - 250));
      else if (r < 7)
        send_point(16'($urandom), 16'($urandom), 16'($urandom_range(0, 65535)));
      else if (r < 9)
        send_read(7'($urandom_range(0, NumChannels - 1)), 7'($urandom_range(0, NumBins - 1)));
      else
        send_read(7'($urandom), 7'($urandom));
    end
  endtask

  task automatic test_random();
    set_radii(15'd870, 15'd30720);
    random_burst(300);
    set_radii(15'($urandom_range(0, 3000)), 15'($urandom_range(8000, 32767)));
    random_burst(250);
    set_radii(15'd100, 15'd2000);
    random_burst(150);
    idling_on = 1'b0;
    set_radii(15'd0, 15'd32767);
    random_burst(200);
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (idling_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cell_result_t seen, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen = '{accepted_o, channel_index_o, bin_index_o, min_height_o};
      results_seen++;
      if (accepted_o) hits_seen++;
      if (pending_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %p", seen);
      end else begin
        want = pending_cells.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, seen);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("polar_grid_min_height_binning verification failed");
      $finish;
    end
  end

  initial begin
    inner_radius = 15'd870;
    outer_radius = 15'd30720;
    foreach (cell_floor[i]) cell_floor[i] = EmptyHeight;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_radius_settings();
    test_random();
    drain();
    $display("covered %0d results, %0d landed or read, radius settings incl. extremes",
             results_seen, hits_seen);
    if (mismatches == 0 && pending_cells.size() == 0) begin
      $display("polar_grid_min_height_binning verification clean");
    end else begin
      $display("polar_grid_min_height_binning verification failed");
    end
    $finish;
  end
endmodule
